@@ hw/rtl/rhc_pkg.sv @@
// Shared types and constants for the RGB/HSV pixel converter.
// No dependencies; every other file of the converter imports this package.
package rhc_pkg;

    localparam int CH_BITS    = 12;
    localparam int LANES      = 3;
    localparam int NUM_BITS   = 37;
    localparam int DEN_BITS   = 26;
    localparam int DIV_BITS   = DEN_BITS + 1;
    localparam int REM_BITS   = 40;
    localparam int Q_BITS     = CH_BITS + 1;
    localparam int DIV_STAGES = Q_BITS;
    localparam int FRONT_STAGES = 3;

    localparam logic [CH_BITS-1:0] CH_MAX  = {CH_BITS{1'b1}};
    localparam logic [24:0]        DEN_REV = 25'd16773120;

    localparam logic DIR_TO_HSV = 1'b0;
    localparam logic DIR_TO_RGB = 1'b1;

    localparam logic [2:0] SEC_RY = 3'd0;
    localparam logic [2:0] SEC_YG = 3'd1;
    localparam logic [2:0] SEC_GC = 3'd2;
    localparam logic [2:0] SEC_CB = 3'd3;
    localparam logic [2:0] SEC_BM = 3'd4;

    typedef struct packed {
        logic [CH_BITS-1:0] comp_first;
        logic [CH_BITS-1:0] comp_second;
        logic [CH_BITS-1:0] comp_third;
    } pix_in_t;

    typedef struct packed {
        logic [CH_BITS-1:0] res_first;
        logic [CH_BITS-1:0] res_second;
        logic [CH_BITS-1:0] res_third;
        logic               achromatic;
    } pix_out_t;

    typedef struct packed {
        logic               dir;
        logic               achrom;
        logic [CH_BITS-1:0] val;
        logic [2:0]         sec;
    } side_t;

    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic [DIV_BITS-1:0] dvs;
        logic [Q_BITS-1:0]   quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        side_t                 side;
    } div_word_t;

endpackage

@@ hw/rtl/rgb_hsv_converter.sv @@
// Top level of the RGB/HSV pixel converter: handshake, valid chain, output mux.
// Depends on rhc_pkg, rhc_front and rhc_div.
//
//   Channel   Signals                      Beat carries
//   --------  ---------------------------  ------------------------------
//   input     in_valid, in_stall, in_data  one pixel (pix_in_t)
//   output    out_valid, out_stall, out_data  one converted pixel (pix_out_t)
//   config    cfg_valid, cfg_ready, cfg_data  direction bit
//
// The block takes one beat per clock while in_stall is low; each pixel passes through
// three front stages, thirteen divider stages (one quotient bit each), and
// the output register.
// Reset clears the direction register and every stage valid bit.
// A stall only holds stages that carry a pixel; empty stages keep filling,
// so bubbles close up and input is taken while a result waits.
module rgb_hsv_converter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rhc_pkg::pix_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rhc_pkg::pix_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import rhc_pkg::*;

    localparam int NS = FRONT_STAGES + DIV_STAGES + 1;

    logic              dir_reg;
    logic [NS-1:0]     vld_reg, vld_next;
    logic [NS:0]       rdy;
    div_word_t         front_out, div_out;
    pix_out_t          out_data_reg, out_data_next;
    logic [CH_BITS-1:0] p, q, t, v;

    // The direction register may be written at any time; it is sampled
    // with each pixel as it enters, so it only affects later pixels.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= DIR_TO_HSV;
        else if (cfg_valid)
            dir_reg <= cfg_data;
    end

    // A stage may load when it is empty or when the stage after it moves.
    always_comb
    begin
        rdy[NS] = ~out_stall;
        for (int i = NS - 1; i >= 0; i--)
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NS; i++)
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_stall = ~rdy[0];

    rhc_front u_front (
        .clk       (clk),
        .en        (rdy[FRONT_STAGES-1:0]),
        .dir       (dir_reg),
        .in_data   (in_data),
        .front_out (front_out)
    );

    rhc_div u_div (
        .clk   (clk),
        .en    (rdy[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
        .d_in  (front_out),
        .d_out (div_out)
    );

    // Lane 0 carries hue (forward) or p, lane 1 saturation or q, lane 2 t.
    always_comb
    begin
        p = div_out.lane[0].quo[CH_BITS-1:0];
        q = div_out.lane[1].quo[CH_BITS-1:0];
        t = div_out.lane[2].quo[CH_BITS-1:0];
        v = div_out.side.val;
        out_data_next.achromatic = div_out.side.achrom;
        if (div_out.side.dir == DIR_TO_HSV)
        begin
            // A hue that rounds up to a full turn drops its top bit and wraps.
            out_data_next.res_first  = div_out.side.achrom ? '0 : p;
            out_data_next.res_second = div_out.side.achrom ? '0 : q;
            out_data_next.res_third  = v;
        end
        else if (div_out.side.achrom)
        begin
            out_data_next.res_first  = v;
            out_data_next.res_second = v;
            out_data_next.res_third  = v;
        end
        else
        begin
            case (div_out.side.sec)
                SEC_RY:
                begin
                    out_data_next.res_first  = v;
                    out_data_next.res_second = t;
                    out_data_next.res_third  = p;
                end
                SEC_YG:
                begin
                    out_data_next.res_first  = q;
                    out_data_next.res_second = v;
                    out_data_next.res_third  = p;
                end
                SEC_GC:
                begin
                    out_data_next.res_first  = p;
                    out_data_next.res_second = v;
                    out_data_next.res_third  = t;
                end
                SEC_CB:
                begin
                    out_data_next.res_first  = p;
                    out_data_next.res_second = q;
                    out_data_next.res_third  = v;
                end
                SEC_BM:
                begin
                    out_data_next.res_first  = t;
                    out_data_next.res_second = p;
                    out_data_next.res_third  = v;
                end
                default:
                begin
                    out_data_next.res_first  = v;
                    out_data_next.res_second = p;
                    out_data_next.res_third  = q;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1]) out_data_reg <= out_data_next;
    end

    assign out_valid = vld_reg[NS-1];
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/rhc_front.sv @@
// Front end of the converter: extremes, sector split, products and rounding setup.
// Depends on rhc_pkg; feeds the divider pipeline rhc_div.
module rhc_front (
    input  logic              clk,
    input  logic [2:0]        en,
    input  logic              dir,
    input  rhc_pkg::pix_in_t  in_data,
    output rhc_pkg::div_word_t front_out
);
    import rhc_pkg::*;

    typedef struct packed {
        logic               dir;
        logic [CH_BITS-1:0] a;
        logic [CH_BITS-1:0] b;
        logic [CH_BITS-1:0] c;
        logic [CH_BITS-1:0] mx;
        logic [CH_BITS-1:0] mn;
        logic               rmax;
        logic               gmax;
        logic [2:0]         sec;
        logic [23:0]        sf;
        logic [24:0]        sfc;
    } s1_t;

    typedef struct packed {
        logic [LANES-1:0][NUM_BITS-1:0] num;
        logic [LANES-1:0][DEN_BITS-1:0] den;
        side_t                          side;
    } s2_t;

    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    div_word_t s3_reg, s3_next;

    logic [14:0]        h6;
    logic [CH_BITS-1:0] fr;

    // Stage 1: max and min of the color, and hue sector and saturation products.
    always_comb
    begin
        s1_next     = '0;
        s1_next.dir = dir;
        s1_next.a   = in_data.comp_first;
        s1_next.b   = in_data.comp_second;
        s1_next.c   = in_data.comp_third;
        s1_next.mx  = in_data.comp_first;
        s1_next.mn  = in_data.comp_first;
        if (in_data.comp_second > s1_next.mx) s1_next.mx = in_data.comp_second;
        if (in_data.comp_third  > s1_next.mx) s1_next.mx = in_data.comp_third;
        if (in_data.comp_second < s1_next.mn) s1_next.mn = in_data.comp_second;
        if (in_data.comp_third  < s1_next.mn) s1_next.mn = in_data.comp_third;
        s1_next.rmax = (in_data.comp_first == s1_next.mx);
        s1_next.gmax = (in_data.comp_second == s1_next.mx);
        h6           = 15'(in_data.comp_first) * 15'd6;
        fr           = h6[CH_BITS-1:0];
        s1_next.sec  = h6[14:12];
        s1_next.sf   = 24'(in_data.comp_second) * 24'(fr);
        s1_next.sfc  = 25'(in_data.comp_second) * (25'd4096 - 25'(fr));
    end

    // Stage 2: numerators and denominators of the three divider lanes.
    logic [CH_BITS-1:0] d;
    logic [14:0]        d6;
    logic [15:0]        n;

    always_comb
    begin
        s2_next = '0;
        d  = s1_reg.mx - s1_reg.mn;
        d6 = 15'(d) * 15'd6;
        if (s1_reg.rmax)
        begin
            if (s1_reg.b >= s1_reg.c)
                n = 16'(s1_reg.b) - 16'(s1_reg.c);
            else
                n = 16'(d6) - (16'(s1_reg.c) - 16'(s1_reg.b));
        end
        else if (s1_reg.gmax)
            n = 16'({d, 1'b0}) + 16'(s1_reg.c) - 16'(s1_reg.a);
        else
            n = 16'({d, 2'b0}) + 16'(s1_reg.a) - 16'(s1_reg.b);

        s2_next.side.dir = s1_reg.dir;
        s2_next.side.sec = s1_reg.sec;
        if (s1_reg.dir == DIR_TO_HSV)
        begin
            s2_next.num[0]      = NUM_BITS'({n[14:0], 12'b0});
            s2_next.den[0]      = DEN_BITS'(d6);
            s2_next.num[1]      = NUM_BITS'({d, 12'b0}) - NUM_BITS'(d);
            s2_next.den[1]      = DEN_BITS'(s1_reg.mx);
            s2_next.num[2]      = '0;
            s2_next.den[2]      = DEN_BITS'(1);
            s2_next.side.achrom = (s1_reg.mx == s1_reg.mn);
            s2_next.side.val    = s1_reg.mx;
        end
        else
        begin
            s2_next.num[0] = NUM_BITS'(24'(s1_reg.c) * 24'(CH_MAX - s1_reg.b));
            s2_next.den[0] = DEN_BITS'(CH_MAX);
            s2_next.num[1] = NUM_BITS'(s1_reg.c) * NUM_BITS'(DEN_REV - 25'(s1_reg.sf));
            s2_next.den[1] = DEN_BITS'(DEN_REV);
            s2_next.num[2] = NUM_BITS'(s1_reg.c) * NUM_BITS'(DEN_REV - s1_reg.sfc);
            s2_next.den[2] = DEN_BITS'(DEN_REV);
            s2_next.side.achrom = (s1_reg.b == '0);
            s2_next.side.val    = s1_reg.c;
        end
    end

    // Stage 3: round to nearest with ties up as floor((2n + d) / 2d).
    always_comb
    begin
        s3_next.side = s2_reg.side;
        for (int l = 0; l < LANES; l++)
        begin
            s3_next.lane[l].rem = REM_BITS'({s2_reg.num[l], 1'b0}) + REM_BITS'(s2_reg.den[l]);
            s3_next.lane[l].dvs = {s2_reg.den[l], 1'b0};
            s3_next.lane[l].quo = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) s1_reg <= s1_next;
        if (en[1]) s2_reg <= s2_next;
        if (en[2]) s3_reg <= s3_next;
    end

    assign front_out = s3_reg;

endmodule

@@ hw/rtl/rhc_div.sv @@
// Restoring divider pipeline, one quotient bit per stage for three lanes.
// Depends on rhc_pkg; fed by rhc_front.
module rhc_div (
    input  logic                             clk,
    input  logic [rhc_pkg::DIV_STAGES-1:0]   en,
    input  rhc_pkg::div_word_t               d_in,
    output rhc_pkg::div_word_t               d_out
);
    import rhc_pkg::*;

    div_word_t stg_reg [DIV_STAGES];

    function automatic div_lane_t div_step(div_lane_t x, int sh);
        logic [REM_BITS-1:0] trial;
        div_lane_t           y;
        y     = x;
        trial = REM_BITS'(x.dvs) << sh;
        if (x.rem >= trial)
        begin
            y.rem     = x.rem - trial;
            y.quo[sh] = 1'b1;
        end
        return y;
    endfunction

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        div_word_t src;
        div_word_t stage_next;

        if (j == 0)
        begin : g_first
            assign src = d_in;
        end
        else
        begin : g_rest
            assign src = stg_reg[j-1];
        end

        always_comb
        begin
            stage_next = src;
            for (int l = 0; l < LANES; l++)
                stage_next.lane[l] = div_step(src.lane[l], Q_BITS - 1 - j);
        end

        always_ff @(posedge clk)
        begin
            if (en[j]) stg_reg[j] <= stage_next;
        end
    end

    assign d_out = stg_reg[DIV_STAGES-1];

endmodule

@@ hw/rtl/rhc_checker.sv @@
// Port-level checker for the RGB/HSV converter, bound to the top level.
// Depends on rhc_pkg and on the rgb_hsv_converter port list.
module rhc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input rhc_pkg::pix_in_t  in_data,
    input logic              out_valid,
    input logic              out_stall,
    input rhc_pkg::pix_out_t out_data,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic              cfg_data
);
    import rhc_pkg::*;

    logic dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= DIR_TO_HSV;
        else if (cfg_valid && cfg_ready)
            dir_reg <= cfg_data;
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input beat dropped or changed under stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat dropped or changed under stall");

    a_grey_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.achromatic && dir_reg == DIR_TO_HSV
        |-> out_data.res_first == '0 && out_data.res_second == '0)
        else $error("grey pixel with nonzero hue or saturation");

    a_grey_rev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.achromatic && dir_reg == DIR_TO_RGB
        |-> out_data.res_first == out_data.res_third
            && out_data.res_second == out_data.res_third)
        else $error("zero saturation gave unequal color channels");

    a_fwd_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dir_reg == DIR_TO_HSV && out_data.res_third == '0
        |-> out_data.achromatic)
        else $error("black pixel not flagged achromatic");

endmodule

bind rgb_hsv_converter rhc_checker u_rhc_checker (.*);
